// ----- hdl/aesd_pkg.sv -----
`timescale 1ns / 1ps
package aesd_pkg;

    localparam int RoundKeyWordsDefault = 60;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth = 64;

    typedef enum logic [2:0] {
        REG_KEY_WORD_0 = 3'd0,
        REG_KEY_WORD_1 = 3'd1,
        REG_KEY_WORD_2 = 3'd2,
        REG_KEY_WORD_3 = 3'd3,
        REG_KEY_LENGTH_MODE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_LOAD,
        ST_ROUND,
        ST_LAST,
        ST_DONE
    } state_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h00;
        for (int v = 0; v < 256; v++)
        begin
            if (FWD_SBOX[v] == x)
            begin
                r = 8'(v);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

endpackage

// ----- hdl/aesd_round.sv -----
`timescale 1ns / 1ps
module aesd_round
(
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         skip_mix,
    output logic [127:0] state_out
);
    import aesd_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, a0x2, a0x4, a0x8, a1x2, a1x4, a1x8;
    logic [7:0] a2x2, a2x4, a2x8, a3x2, a3x4, a3x8;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8*i -: 8];
        end
        // inverse shift rows and inverse sub bytes, then the key add
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4*((c + r) % 4) + r] = inv_sbox(s[4*c + r]);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            t[i] = t[i] ^ round_key[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            a0x2 = xtime(a0); a0x4 = xtime(a0x2); a0x8 = xtime(a0x4);
            a1x2 = xtime(a1); a1x4 = xtime(a1x2); a1x8 = xtime(a1x4);
            a2x2 = xtime(a2); a2x4 = xtime(a2x2); a2x8 = xtime(a2x4);
            a3x2 = xtime(a3); a3x4 = xtime(a3x2); a3x8 = xtime(a3x4);
            m[4*c]   = (a0x8^a0x4^a0x2) ^ (a1x8^a1x2^a1) ^ (a2x8^a2x4^a2) ^ (a3x8^a3);
            m[4*c+1] = (a0x8^a0) ^ (a1x8^a1x4^a1x2) ^ (a2x8^a2x2^a2) ^ (a3x8^a3x4^a3);
            m[4*c+2] = (a0x8^a0x4^a0) ^ (a1x8^a1) ^ (a2x8^a2x4^a2x2) ^ (a3x8^a3x2^a3);
            m[4*c+3] = (a0x8^a0x2^a0) ^ (a1x8^a1x4^a1) ^ (a2x8^a2) ^ (a3x8^a3x4^a3x2);
        end
        for (int i = 0; i < 16; i++)
        begin
            state_out[127 - 8*i -: 8] = skip_mix ? t[i] : m[i];
        end
    end

endmodule

// ----- hdl/aes_ecb_block_decrypt.sv -----
`timescale 1ns / 1ps
// aes-128/256 ecb decryption, one 128-bit block per request
// configuration: cfg_we, cfg_index, cfg_data write the key words (0..3) and the
// key length mode (4); write only while busy is low. any register write marks the
// round keys stale
// request: start with busy low takes cipher; busy stays high until the result
// result: done pulses for one cycle with plain valid; the receiver cannot stall
// expansion: after a configuration change the first request first runs the key
// schedule, one round key word per cycle, set by the single expansion word path,
// then a fetch state reads the last round key, then decryption follows
// decryption does the initial key add, then each round through the shared round
// unit (10 or 14 rounds), then a result state in which done pulses
// a new request is taken only from idle, once the previous result is out
// round keys come from a 128-bit-wide view of a word store, read one row a cycle
// reset clears control and restores the key length mode to aes-256 with a zero key;
// the round key store itself holds no reset value and is always refilled before use
module aes_ecb_block_decrypt
#(
    parameter int ROUND_KEY_WORDS = aesd_pkg::RoundKeyWordsDefault
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [aesd_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [aesd_pkg::CfgDataWidth-1:0]    cfg_data,
    input  logic                                 start,
    input  aesd_pkg::cipher_t                    cipher,
    output logic                                 busy,
    output logic                                 done,
    output aesd_pkg::plain_t                     plain
);
    import aesd_pkg::*;

    localparam int Rows = (ROUND_KEY_WORDS + 3) / 4;
    localparam int RowW = $clog2(Rows + 1);
    localparam int WordW = $clog2(60 + 1);

    logic [63:0] key_reg [4];
    logic        mode_reg;
    logic        ready_reg;
    state_t      state_reg, state_next;
    logic [WordW-1:0] widx_reg, widx_next;
    logic [RowW-1:0]  rnd_reg, rnd_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] win_reg [8];
    logic [127:0] data_reg, data_next;
    logic [127:0] rk_mem [Rows];
    logic [127:0] rk_row;
    logic [127:0] rd_mask;
    logic [127:0] round_out;
    logic [31:0] new_word, tword;
    logic [2:0]  phase;
    logic        last_word, wr_word;
    logic [3:0]  nr;
    logic [RowW-1:0] rd_row;

    assign nr = mode_reg ? 4'd14 : 4'd10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            mode_reg  <= 1'b1;
            ready_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0: begin key_reg[0] <= cfg_data; ready_reg <= 1'b0; end
                REG_KEY_WORD_1: begin key_reg[1] <= cfg_data; ready_reg <= 1'b0; end
                REG_KEY_WORD_2: begin key_reg[2] <= cfg_data; ready_reg <= 1'b0; end
                REG_KEY_WORD_3: begin key_reg[3] <= cfg_data; ready_reg <= 1'b0; end
                REG_KEY_LENGTH_MODE: begin mode_reg <= cfg_data[0]; ready_reg <= 1'b0; end
                default: ;
            endcase
        end
        else if (state_reg == ST_EXPAND && last_word)
        begin
            ready_reg <= 1'b1;
        end
    end

    // key schedule: sliding window of the last eight words
    always_comb
    begin
        tword = win_reg[7];
        phase = mode_reg ? widx_reg[2:0] : {1'b0, widx_reg[1:0]};
        if (widx_reg < 8 && (mode_reg || widx_reg < 4))
        begin
            new_word = widx_reg[0] ? key_reg[widx_reg[2:1]][31:0]
                                   : key_reg[widx_reg[2:1]][63:32];
        end
        else
        begin
            if (phase == 3'd0)
            begin
                tword = sub_word({tword[23:0], tword[31:24]}) ^ {rcon_reg, 24'h0};
            end
            else if (mode_reg && phase == 3'd4)
            begin
                tword = sub_word(tword);
            end
            new_word = (mode_reg ? win_reg[0] : win_reg[4]) ^ tword;
        end
        last_word = widx_reg == (mode_reg ? WordW'(59) : WordW'(43));
        wr_word = state_reg == ST_EXPAND && widx_reg < WordW'(ROUND_KEY_WORDS);
    end

    // words past the end of the store read as zero
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rd_mask[127 - 32*j -: 32] = ({rd_row, 2'(j)} < ROUND_KEY_WORDS) ? {32{1'b1}}
                                                                           : 32'h0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[7] <= new_word;
        end
        if (wr_word)
        begin
            rk_mem[widx_reg[WordW-1:2]][127 - 32*widx_reg[1:0] -: 32] <= new_word;
        end
        rk_row <= rk_mem[rd_row] & rd_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            widx_reg  <= '0;
            rnd_reg   <= '0;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            rnd_reg   <= rnd_next;
            rcon_reg  <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    aesd_round u_round
    (
        .state_in  (data_reg),
        .round_key (rk_row),
        .skip_mix  (state_reg == ST_LAST),
        .state_out (round_out)
    );

    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        rnd_next   = rnd_reg;
        rcon_next  = rcon_reg;
        data_next  = data_reg;
        rd_row     = rnd_reg;
        busy       = state_reg != ST_IDLE;
        done       = state_reg == ST_DONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_row = RowW'(nr);
                if (start)
                begin
                    data_next = cipher;
                    rnd_next  = RowW'(nr);
                    widx_next = '0;
                    rcon_next = 8'h01;
                    state_next = ready_reg ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                rd_row = RowW'(nr);
                widx_next = widx_reg + 1'b1;
                if (widx_reg >= (mode_reg ? WordW'(8) : WordW'(4)) && phase == 3'd0)
                begin
                    rcon_next = xtime(rcon_reg);
                end
                if (last_word)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // the last word written above is visible to this read
                rd_row     = RowW'(nr);
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // rk_row now holds the last round key
                data_next  = data_reg ^ rk_row;
                rnd_next   = rnd_reg - 1'b1;
                rd_row     = rnd_reg - 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                data_next = round_out;
                rnd_next  = rnd_reg - 1'b1;
                rd_row    = rnd_reg - 1'b1;
                if (rnd_reg == RowW'(1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                data_next  = round_out;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign plain = data_reg;

endmodule
